// ----- sv/wblc_pkg.sv -----
// Shared geometry, result codes and word types of the write-back LRU data cache.
package wblc_pkg;

	localparam int unsigned SETS       = 8;
	localparam int unsigned WAYS       = 4;
	localparam int unsigned LINE_WORDS = 8;
	localparam int unsigned SET_W      = $clog2(SETS);
	localparam int unsigned WAY_W      = $clog2(WAYS);
	localparam int unsigned WORD_W     = $clog2(LINE_WORDS);
	localparam int unsigned OFF_W      = WORD_W + 3;
	localparam int unsigned TAG_W      = 32 - OFF_W - SET_W;
	localparam int unsigned SLOT_W     = SET_W + WAY_W;
	localparam int unsigned MEM_AW     = SLOT_W + WORD_W;
	localparam int unsigned RANK_W     = WAY_W;
	localparam logic [1:0]  SIZE_DOUBLE = 2'd3;
	localparam logic        OP_CPU      = 1'b0;
	localparam logic        OP_FILL     = 1'b1;

	localparam logic [2:0] KIND_READ   = 3'd0;
	localparam logic [2:0] KIND_WRITE  = 3'd1;
	localparam logic [2:0] KIND_WBWORD = 3'd2;
	localparam logic [2:0] KIND_FILL   = 3'd3;
	localparam logic [2:0] KIND_BUSY   = 3'd4;

	// One decoded input word as it waits between front and back.
	typedef struct packed {
		logic        op;
		logic [31:0] address;
		logic        is_write;
		logic        is_double;
		logic [63:0] data;
	} cmd_t;

	// One result word as it waits on the output side.
	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] read_data;
		logic [31:0] mem_address;
		logic [63:0] mem_data;
		logic        last;
	} res_t;

endpackage

// ----- sv/wblc_front.sv -----
// Front end: accepts input words, decodes them and queues them for the back end.
module wblc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              op,
	input  logic [31:0]       address,
	input  logic              is_write,
	input  logic [1:0]        size_code,
	input  logic [63:0]       write_data,
	input  logic [63:0]       fill_data,
	output logic              cmd_valid,
	output wblc_pkg::cmd_t    cmd,
	input  logic              cmd_pop
);

	wblc_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic           do_pop;
	wblc_pkg::cmd_t dec;

	// Fill words and cpu stores share one data slot.
	always_comb begin
		dec.op        = op;
		dec.address   = address;
		dec.is_write  = is_write;
		dec.is_double = (size_code == wblc_pkg::SIZE_DOUBLE);
		dec.data      = (op == wblc_pkg::OP_FILL) ? fill_data : write_data;
	end

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

// ----- sv/wblc_back.sv -----
// Back end: tag lookup, LRU upkeep, line data memory, miss sequencing and result register.
module wblc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  wblc_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           res_valid,
	output wblc_pkg::res_t res,
	input  logic           res_pop
);

	typedef enum logic [2:0] {
		S_IDLE, S_HIT, S_REPLAY, S_WB_RD, S_WB_EM, S_FILL_REQ
	} state_t;

	state_t state_q;

	logic [wblc_pkg::TAG_W-1:0]  tag_q   [wblc_pkg::WAYS][wblc_pkg::SETS];
	logic [wblc_pkg::WAYS-1:0]   valid_q [wblc_pkg::SETS];
	logic [wblc_pkg::WAYS-1:0]   dirty_q [wblc_pkg::SETS];
	logic [wblc_pkg::RANK_W-1:0] rank_q  [wblc_pkg::SETS][wblc_pkg::WAYS];
	logic [63:0]                 data_mem_q [2**wblc_pkg::MEM_AW];
	logic [63:0]                 rdata_q;

	logic                         miss_open_q;
	logic [31:0]                  pend_addr_q;
	logic                         pend_wr_q;
	logic                         pend_dbl_q;
	logic [63:0]                  pend_wdata_q;
	logic [wblc_pkg::SLOT_W-1:0]  vic_q;
	logic [wblc_pkg::WORD_W-1:0]  fill_cnt_q;
	logic [wblc_pkg::SLOT_W-1:0]  cur_slot_q;
	logic [wblc_pkg::WORD_W-1:0]  cur_word_q;
	logic [2:0]                   cur_byte_q;
	logic                         cur_wr_q;
	logic                         cur_dbl_q;
	logic [63:0]                  cur_wdata_q;
	logic [wblc_pkg::WORD_W-1:0]  wb_idx_q;
	logic [31:0]                  wb_base_q;
	logic                         out_valid_q;
	wblc_pkg::res_t               out_q;

	logic [wblc_pkg::SET_W-1:0]   h_set;
	logic [wblc_pkg::TAG_W-1:0]   h_tag;
	logic [wblc_pkg::WORD_W-1:0]  h_word;
	logic                         hit;
	logic [wblc_pkg::WAY_W-1:0]   hit_way;
	logic [wblc_pkg::WAY_W-1:0]   vic_way;
	logic                         vic_found;
	logic [wblc_pkg::RANK_W-1:0]  low_rank;
	logic                         take;
	logic                         mem_re;
	logic [wblc_pkg::MEM_AW-1:0]  mem_raddr;
	logic                         mem_we;
	logic [wblc_pkg::MEM_AW-1:0]  mem_waddr;
	logic [63:0]                  mem_wdata;
	logic [5:0]                   sh;
	logic [63:0]                  merged;
	logic [63:0]                  rd_result;
	logic [wblc_pkg::SET_W-1:0]   c_set;
	logic [wblc_pkg::WAY_W-1:0]   c_way;

	assign h_set  = cmd.address[wblc_pkg::OFF_W +: wblc_pkg::SET_W];
	assign h_tag  = cmd.address[31 -: wblc_pkg::TAG_W];
	assign h_word = cmd.address[3 +: wblc_pkg::WORD_W];
	assign c_set  = cur_slot_q[wblc_pkg::WAY_W +: wblc_pkg::SET_W];
	assign c_way  = cur_slot_q[wblc_pkg::WAY_W-1:0];
	assign take   = (state_q == S_IDLE) && cmd_valid && !out_valid_q;
	assign cmd_pop = take;

	// Way lookup and victim choice: first invalid way, else lowest rank.
	always_comb begin
		hit       = 1'b0;
		hit_way   = '0;
		vic_found = 1'b0;
		vic_way   = '0;
		low_rank  = '1;
		for (int w = wblc_pkg::WAYS - 1; w >= 0; w--) begin
			if (valid_q[h_set][w] && tag_q[w][h_set] == h_tag) begin
				hit     = 1'b1;
				hit_way = wblc_pkg::WAY_W'(w);
			end
		end
		for (int w = 0; w < wblc_pkg::WAYS; w++) begin
			if (!vic_found) begin
				if (!valid_q[h_set][w]) begin
					vic_found = 1'b1;
					vic_way   = wblc_pkg::WAY_W'(w);
				end else if (rank_q[h_set][w] < low_rank || w == 0) begin
					low_rank = rank_q[h_set][w];
					vic_way  = wblc_pkg::WAY_W'(w);
				end
			end
		end
	end

	// Byte lane shift, store merge and load result for the current access.
	always_comb begin
		sh        = {cur_byte_q, 3'b000};
		merged    = (rdata_q & ~(64'hFF << sh)) | ({56'd0, cur_wdata_q[7:0]} << sh);
		rd_result = cur_dbl_q ? rdata_q : ((rdata_q >> sh) & 64'hFF);
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = {cur_slot_q, wb_idx_q};
		mem_we    = 1'b0;
		mem_waddr = {vic_q, fill_cnt_q};
		mem_wdata = cmd.data;
		if (take && cmd.op == wblc_pkg::OP_CPU && !miss_open_q && hit) begin
			mem_re    = 1'b1;
			mem_raddr = {h_set, hit_way, h_word};
		end else if (state_q == S_REPLAY) begin
			mem_re    = 1'b1;
			mem_raddr = {cur_slot_q, cur_word_q};
		end else if (state_q == S_WB_RD) begin
			mem_re = 1'b1;
		end
		if (take && cmd.op == wblc_pkg::OP_FILL && miss_open_q) begin
			mem_we = 1'b1;
		end else if (state_q == S_HIT && cur_wr_q) begin
			mem_we    = 1'b1;
			mem_waddr = {cur_slot_q, cur_word_q};
			mem_wdata = cur_dbl_q ? cur_wdata_q : merged;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			data_mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= data_mem_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			miss_open_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			pend_addr_q <= '0;
			pend_wr_q   <= 1'b0;
			pend_dbl_q  <= 1'b0;
			pend_wdata_q <= '0;
			vic_q       <= '0;
			fill_cnt_q  <= '0;
			cur_slot_q  <= '0;
			cur_word_q  <= '0;
			cur_byte_q  <= '0;
			cur_wr_q    <= 1'b0;
			cur_dbl_q   <= 1'b0;
			cur_wdata_q <= '0;
			wb_idx_q    <= '0;
			wb_base_q   <= '0;
			for (int s = 0; s < wblc_pkg::SETS; s++) begin
				valid_q[s] <= '0;
				dirty_q[s] <= '0;
				for (int w = 0; w < wblc_pkg::WAYS; w++) begin
					tag_q[w][s]  <= '0;
					rank_q[s][w] <= wblc_pkg::RANK_W'(w);
				end
			end
		end else begin
			if (res_pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						if (cmd.op == wblc_pkg::OP_FILL) begin
							if (miss_open_q) begin
								if (fill_cnt_q == wblc_pkg::WORD_W'(wblc_pkg::LINE_WORDS - 1)) begin
									tag_q[vic_q[wblc_pkg::WAY_W-1:0]][vic_q[wblc_pkg::WAY_W +: wblc_pkg::SET_W]]
										<= pend_addr_q[31 -: wblc_pkg::TAG_W];
									valid_q[vic_q[wblc_pkg::WAY_W +: wblc_pkg::SET_W]][vic_q[wblc_pkg::WAY_W-1:0]] <= 1'b1;
									dirty_q[vic_q[wblc_pkg::WAY_W +: wblc_pkg::SET_W]][vic_q[wblc_pkg::WAY_W-1:0]] <= 1'b0;
									fill_cnt_q  <= '0;
									cur_slot_q  <= vic_q;
									cur_word_q  <= pend_addr_q[3 +: wblc_pkg::WORD_W];
									cur_byte_q  <= pend_addr_q[2:0];
									cur_wr_q    <= pend_wr_q;
									cur_dbl_q   <= pend_dbl_q;
									cur_wdata_q <= pend_wdata_q;
									state_q     <= S_REPLAY;
								end else begin
									fill_cnt_q <= fill_cnt_q + 1'b1;
								end
							end
						end else if (miss_open_q) begin
							out_valid_q <= 1'b1;
							out_q       <= '{wblc_pkg::KIND_BUSY, 64'd0, 32'd0, 64'd0, 1'b1};
						end else if (hit) begin
							cur_slot_q  <= {h_set, hit_way};
							cur_word_q  <= h_word;
							cur_byte_q  <= cmd.address[2:0];
							cur_wr_q    <= cmd.is_write;
							cur_dbl_q   <= cmd.is_double;
							cur_wdata_q <= cmd.data;
							state_q     <= S_HIT;
						end else begin
							pend_addr_q  <= cmd.address;
							pend_wr_q    <= cmd.is_write;
							pend_dbl_q   <= cmd.is_double;
							pend_wdata_q <= cmd.data;
							vic_q        <= {h_set, vic_way};
							miss_open_q  <= 1'b1;
							fill_cnt_q   <= '0;
							if (valid_q[h_set][vic_way] && dirty_q[h_set][vic_way]) begin
								cur_slot_q <= {h_set, vic_way};
								wb_idx_q   <= '0;
								wb_base_q  <= {tag_q[vic_way][h_set], h_set, wblc_pkg::OFF_W'(0)};
								state_q    <= S_WB_RD;
							end else begin
								out_valid_q <= 1'b1;
								out_q       <= '{wblc_pkg::KIND_FILL, 64'd0,
									{cmd.address[31:wblc_pkg::OFF_W], wblc_pkg::OFF_W'(0)}, 64'd0, 1'b1};
							end
						end
					end
				end
				S_REPLAY: begin
					state_q <= S_HIT;
				end
				S_HIT: begin
					// Move the accessed way to the top, lower the ranks above it.
					for (int w = 0; w < wblc_pkg::WAYS; w++) begin
						if (rank_q[c_set][w] > rank_q[c_set][c_way]) begin
							rank_q[c_set][w] <= rank_q[c_set][w] - 1'b1;
						end
					end
					rank_q[c_set][c_way] <= wblc_pkg::RANK_W'(wblc_pkg::WAYS - 1);
					if (cur_wr_q) begin
						dirty_q[c_set][c_way] <= 1'b1;
						out_q <= '{wblc_pkg::KIND_WRITE, 64'd0, 32'd0, 64'd0, 1'b1};
					end else begin
						out_q <= '{wblc_pkg::KIND_READ, rd_result, 32'd0, 64'd0, 1'b1};
					end
					out_valid_q <= 1'b1;
					miss_open_q <= 1'b0;
					state_q     <= S_IDLE;
				end
				S_WB_RD: begin
					state_q <= S_WB_EM;
				end
				S_WB_EM: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_q       <= '{wblc_pkg::KIND_WBWORD, 64'd0,
							{wb_base_q[31:wblc_pkg::OFF_W], wb_idx_q, 3'b000}, rdata_q, 1'b0};
						wb_idx_q    <= wb_idx_q + 1'b1;
						if (wb_idx_q == wblc_pkg::WORD_W'(wblc_pkg::LINE_WORDS - 1)) begin
							state_q <= S_FILL_REQ;
						end else begin
							state_q <= S_WB_RD;
						end
					end
				end
				S_FILL_REQ: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_q       <= '{wblc_pkg::KIND_FILL, 64'd0,
							{pend_addr_q[31:wblc_pkg::OFF_W], wblc_pkg::OFF_W'(0)}, 64'd0, 1'b1};
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

// ----- sv/write_back_lru_data_cache_top.sv -----
// Write-back 8-set, 4-way LRU data cache with 64-byte lines: a two-word input queue feeds
// the lookup engine, which owns the tag, LRU and line data stores and a one-word result
// register. A hit at the queue head takes a data memory read, then update and result;
// a busy answer or a fill word is handled in the idle state. A miss to a clean or empty
// way gives its fill request directly; a dirty victim streams its eight words out, each a
// data memory read then an emit (one data memory read port), then the fill request. The
// eighth fill word installs the line and replays the held access (read, update, result).
// Results wait in the output register until popped; the engine stalls while it is full.
module write_back_lru_data_cache_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        op,
	input  logic [31:0] address,
	input  logic        is_write,
	input  logic [1:0]  size_code,
	input  logic [63:0] write_data,
	input  logic [63:0] fill_data,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  kind,
	output logic [63:0] read_data,
	output logic [31:0] mem_address,
	output logic [63:0] mem_data,
	output logic        last
);

	logic           cmd_valid;
	wblc_pkg::cmd_t cmd;
	logic           cmd_pop;
	logic           res_valid;
	wblc_pkg::res_t res;

	wblc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.op         (op),
		.address    (address),
		.is_write   (is_write),
		.size_code  (size_code),
		.write_data (write_data),
		.fill_data  (fill_data),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	wblc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_pop   (pop)
	);

	assign empty       = !res_valid;
	assign kind        = res.kind;
	assign read_data   = res.read_data;
	assign mem_address = res.mem_address;
	assign mem_data    = res.mem_data;
	assign last        = res.last;

endmodule

// ----- sv/wblc_checker.sv -----
// Port-level checks on the result side of the cache, bound to the top level.
module wblc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [2:0]  kind,
	input logic [63:0] read_data,
	input logic [31:0] mem_address,
	input logic [63:0] mem_data,
	input logic        last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(kind) && $stable(mem_address)))
		else $error("result word changed while waiting");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (kind == wblc_pkg::KIND_READ || kind == wblc_pkg::KIND_WRITE ||
			kind == wblc_pkg::KIND_WBWORD || kind == wblc_pkg::KIND_FILL ||
			kind == wblc_pkg::KIND_BUSY))
		else $error("bad result kind");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last == (kind != wblc_pkg::KIND_WBWORD)))
		else $error("last flag does not match kind");

	a_wb_then_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && kind == wblc_pkg::KIND_WBWORD && mem_address[5:3] == 3'd7)
		|=> (empty || kind == wblc_pkg::KIND_FILL))
		else $error("writeback burst not followed by fill request");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind != wblc_pkg::KIND_WBWORD) |-> (mem_data == 64'd0))
		else $error("memory data set outside writeback");

endmodule

bind write_back_lru_data_cache_top wblc_checker u_wblc_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for the write-back LRU data cache: random and directed words.
module tb;

	localparam int unsigned LIMIT = 300000;

	typedef struct {
		logic        op;
		logic [31:0] address;
		logic        is_write;
		logic [1:0]  size_code;
		logic [63:0] write_data;
		logic [63:0] fill_data;
	} word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        op = wblc_pkg::OP_CPU;
	logic [31:0] address = '0;
	logic        is_write = 1'b0;
	logic [1:0]  size_code = '0;
	logic [63:0] write_data = '0;
	logic [63:0] fill_data = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [2:0]  kind;
	logic [63:0] read_data;
	logic [31:0] mem_address;
	logic [63:0] mem_data;
	logic        last;

	write_back_lru_data_cache_top u_top (.*);

	always #10 clk = ~clk;

	// cache shadow
	logic [63:0]      line_data [wblc_pkg::SETS*wblc_pkg::WAYS][wblc_pkg::LINE_WORDS];
	logic [wblc_pkg::TAG_W-1:0] line_tag [wblc_pkg::SETS*wblc_pkg::WAYS];
	logic             line_valid [wblc_pkg::SETS*wblc_pkg::WAYS];
	logic             line_dirty [wblc_pkg::SETS*wblc_pkg::WAYS];
	logic [1:0]       lru_rank [wblc_pkg::SETS*wblc_pkg::WAYS];
	logic             miss_open;
	logic [31:0]      held_addr;
	logic             held_write;
	logic [1:0]       held_size;
	logic [63:0]      held_data;
	int unsigned      victim_slot;
	int unsigned      fill_count;

	word_t           stim_q [$];
	wblc_pkg::res_t  cache_results [$];
	int unsigned send_idle = 12;
	int unsigned recv_idle = 56;
	logic        sent = 1'b0;
	int unsigned cycles = 0;
	int unsigned errors = 0;
	int unsigned checked = 0;
	int unsigned accesses = 0;
	logic [wblc_pkg::TAG_W-1:0] tag_pool [6];

	function automatic void touch_way(int unsigned set, int unsigned way);
		logic [1:0] mine;
		mine = lru_rank[set*wblc_pkg::WAYS+way];
		for (int w = 0; w < wblc_pkg::WAYS; w++)
			if (lru_rank[set*wblc_pkg::WAYS+w] > mine)
				lru_rank[set*wblc_pkg::WAYS+w]--;
		lru_rank[set*wblc_pkg::WAYS+way] = 2'd3;
	endfunction

	function automatic void serve_line(int unsigned slot, logic [31:0] a, logic wr,
			logic [1:0] sz, logic [63:0] wd);
		wblc_pkg::res_t r;
		int unsigned wi, sh;
		wi = 32'(a[5:3]);
		sh = 32'(a[2:0]) * 8;
		r = '0;
		r.last = 1'b1;
		if (!wr) begin
			r.kind = wblc_pkg::KIND_READ;
			r.read_data = (sz == wblc_pkg::SIZE_DOUBLE) ? line_data[slot][wi]
				: ((line_data[slot][wi] >> sh) & 64'hFF);
		end else begin
			r.kind = wblc_pkg::KIND_WRITE;
			if (sz == wblc_pkg::SIZE_DOUBLE)
				line_data[slot][wi] = wd;
			else
				line_data[slot][wi] = (line_data[slot][wi] & ~(64'hFF << sh))
					| ((wd & 64'hFF) << sh);
			line_dirty[slot] = 1'b1;
		end
		cache_results.push_back(r);
	endfunction

	function automatic void predict_cache(word_t s);
		wblc_pkg::res_t r;
		int unsigned set, way, slot;
		logic [wblc_pkg::TAG_W-1:0] tg;
		logic [1:0] low;
		set = 32'(s.address[8:6]);
		tg = s.address[31:9];
		if (s.op == wblc_pkg::OP_CPU) begin
			r = '0;
			r.last = 1'b1;
			if (miss_open) begin
				r.kind = wblc_pkg::KIND_BUSY;
				cache_results.push_back(r);
				return;
			end
			for (int w = 0; w < wblc_pkg::WAYS; w++)
				if (line_valid[set*wblc_pkg::WAYS+w] && line_tag[set*wblc_pkg::WAYS+w] == tg) begin
					serve_line(set*wblc_pkg::WAYS+w, s.address, s.is_write, s.size_code,
						s.write_data);
					touch_way(set, w);
					return;
				end
			// invalid way first, else least recently used
			way = wblc_pkg::WAYS;
			low = 2'd3;
			for (int w = wblc_pkg::WAYS - 1; w >= 0; w--)
				if (!line_valid[set*wblc_pkg::WAYS+w])
					way = w;
			if (way == wblc_pkg::WAYS) begin
				way = 0;
				low = lru_rank[set*wblc_pkg::WAYS];
				for (int w = 1; w < wblc_pkg::WAYS; w++)
					if (lru_rank[set*wblc_pkg::WAYS+w] < low) begin
						low = lru_rank[set*wblc_pkg::WAYS+w];
						way = w;
					end
			end
			slot = set*wblc_pkg::WAYS + way;
			victim_slot = slot;
			held_addr = s.address;
			held_write = s.is_write;
			held_size = s.size_code;
			held_data = s.write_data;
			miss_open = 1'b1;
			fill_count = 0;
			if (line_valid[slot] && line_dirty[slot])
				for (int i = 0; i < wblc_pkg::LINE_WORDS; i++) begin
					r = '0;
					r.kind = wblc_pkg::KIND_WBWORD;
					r.mem_address = 32'({line_tag[slot], set[2:0], 6'd0} + i*8);
					r.mem_data = line_data[slot][i];
					cache_results.push_back(r);
				end
			r = '0;
			r.kind = wblc_pkg::KIND_FILL;
			r.mem_address = {s.address[31:6], 6'd0};
			r.last = 1'b1;
			cache_results.push_back(r);
		end else if (miss_open) begin
			line_data[victim_slot][fill_count] = s.fill_data;
			fill_count++;
			if (fill_count == wblc_pkg::LINE_WORDS) begin
				line_tag[victim_slot] = held_addr[31:9];
				line_valid[victim_slot] = 1'b1;
				line_dirty[victim_slot] = 1'b0;
				touch_way(victim_slot / wblc_pkg::WAYS, victim_slot % wblc_pkg::WAYS);
				serve_line(victim_slot, held_addr, held_write, held_size, held_data);
				touch_way(victim_slot / wblc_pkg::WAYS, victim_slot % wblc_pkg::WAYS);
				miss_open = 1'b0;
				fill_count = 0;
			end
		end
	endfunction

	task automatic add_access(logic [31:0] a, logic wr, logic [1:0] sz, logic [63:0] wd);
		word_t s;
		s.op = wblc_pkg::OP_CPU;
		s.address = a;
		s.is_write = wr;
		s.size_code = sz;
		s.write_data = wd;
		s.fill_data = {$urandom, $urandom};
		stim_q.push_back(s);
		accesses++;
	endtask

	task automatic add_fills(int unsigned n);
		word_t s;
		for (int i = 0; i < n; i++) begin
			s.op = wblc_pkg::OP_FILL;
			s.address = $urandom;
			s.is_write = 1'($urandom_range(1));
			s.size_code = 2'($urandom_range(3));
			s.write_data = {$urandom, $urandom};
			s.fill_data = {$urandom, $urandom};
			stim_q.push_back(s);
		end
	endtask

	task automatic add_random_phase(int unsigned n);
		logic [2:0] set;
		logic [1:0] sz;
		for (int i = 0; i < 6; i++)
			tag_pool[i] = wblc_pkg::TAG_W'($urandom);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				add_fills(1);
			set = ($urandom_range(9) < 7) ? 3'($urandom_range(1)) : 3'($urandom_range(7));
			sz = $urandom_range(1) ? wblc_pkg::SIZE_DOUBLE : 2'($urandom_range(2));
			add_access({tag_pool[$urandom_range(5)], set, 6'($urandom)},
				1'($urandom_range(1)), sz, {$urandom, $urandom});
			if ($urandom_range(99) < 85) begin
				if ($urandom_range(99) < 15) begin
					add_fills($urandom_range(7));
					add_access($urandom, 1'($urandom_range(1)), 2'($urandom_range(3)),
						{$urandom, $urandom});
				end
				add_fills(wblc_pkg::LINE_WORDS);
			end
		end
	endtask

	initial begin
		for (int i = 0; i < wblc_pkg::SETS*wblc_pkg::WAYS; i++) begin
			line_tag[i] = '0;
			line_valid[i] = 1'b0;
			line_dirty[i] = 1'b0;
			lru_rank[i] = 2'(i % wblc_pkg::WAYS);
		end
		miss_open = 1'b0;
		fill_count = 0;
		victim_slot = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// stray fill, write miss, busy during the miss, hits of sizes 1 to 3, then another miss
		add_fills(1);
		add_access(32'h0000_0005, 1'b1, 2'd0, 64'hFFFF_FFFF_FFFF_FFA5);
		add_access(32'h0000_0008, 1'b0, wblc_pkg::SIZE_DOUBLE, '0);
		add_fills(wblc_pkg::LINE_WORDS);
		add_access(32'h0000_0005, 1'b0, 2'd1, '0);
		add_access(32'h0000_0003, 1'b0, wblc_pkg::SIZE_DOUBLE, '0);
		add_access(32'h0000_000D, 1'b1, wblc_pkg::SIZE_DOUBLE, 64'hFFFF_FFFF_FFFF_FFFF);
		add_access(32'h0000_0008, 1'b0, 2'd2, '0);
		add_access(32'hFFFF_FFFF, 1'b0, 2'd0, '0);
		add_fills(wblc_pkg::LINE_WORDS);
		add_random_phase(4);
		wait (stim_q.size() == 0);
		send_idle = 56;
		recv_idle = 12;
		add_random_phase(4);
		wait (stim_q.size() == 0);
		send_idle = 0;
		recv_idle = 0;
		add_random_phase(4);
		wait (stim_q.size() == 0);
		do @(posedge clk); while (push || cache_results.size() != 0);
		repeat (40) @(posedge clk);
		errors += cache_results.size();
		$display("Covered %0d cpu accesses with fills, stray and busy words; %0d results checked.",
			accesses, checked);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// driver: advance on acceptance, idle at random
	always @(negedge clk) begin
		word_t s;
		if (arst_n) begin
			if (!push || sent) begin
				if (stim_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					s = stim_q.pop_front();
					op <= s.op;
					address <= s.address;
					is_write <= s.is_write;
					size_code <= s.size_code;
					write_data <= s.write_data;
					fill_data <= s.fill_data;
					push <= 1'b1;
				end else
					push <= 1'b0;
			end
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	// monitor: check popped results, then predict accepted words
	always @(posedge clk) begin
		word_t s;
		wblc_pkg::res_t want;
		if (arst_n) begin
			cycles++;
			if (cycles > LIMIT) begin
				$display("Mismatches found");
				$finish;
			end else begin
				if (pop && !empty) begin
					checked++;
					if (cache_results.size() == 0) begin
						errors++;
						if (errors <= 10)
							$display("unexpected result kind=%0d", kind);
					end else begin
						want = cache_results.pop_front();
						if (kind !== want.kind || read_data !== want.read_data
								|| mem_address !== want.mem_address
								|| mem_data !== want.mem_data || last !== want.last) begin
							errors++;
							if (errors <= 10)
								$display("result %0d: exp %0d %h %h %h %b got %0d %h %h %h %b",
									checked, want.kind, want.read_data, want.mem_address,
									want.mem_data, want.last, kind, read_data,
									mem_address, mem_data, last);
						end
					end
				end
				sent = push && !full;
				if (sent) begin
					s.op = op;
					s.address = address;
					s.is_write = is_write;
					s.size_code = size_code;
					s.write_data = write_data;
					s.fill_data = fill_data;
					predict_cache(s);
				end
			end
		end
	end

endmodule
